>>> rtl/mkds_pkg.sv
package mkds_pkg;

    localparam int KEY_SLOTS = 8;
    localparam int CNT_W     = 8;
    localparam int REG_IDX_W = 3;
    localparam int WDATA_W   = 64;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KEY_PRESENT     = 3'd0,
        REG_ACTIVE_LEVEL    = 3'd1,
        REG_REPEAT          = 3'd2,
        REG_RELEASE_TRIGGER = 3'd3,
        REG_TIMEOUT_TICKS   = 3'd4
    } reg_index_t;

    // Settings that one key lane sees.
    typedef struct packed {
        logic             present;
        logic             active_level;
        logic             repeat_en;
        logic             release_trig;
        logic [CNT_W-1:0] timeout;
    } key_cfg_t;

    // What one lane reports after a scan.
    typedef struct packed {
        logic active;
        logic held;
    } key_status_t;

endpackage

>>> rtl/mkds_if.sv
interface mkds_scan_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_levels;
    logic [7:0] ack_mask;

    modport source (output valid, output raw_levels, output ack_mask, input ready);
    modport sink (input valid, input raw_levels, input ack_mask, output ready);
endinterface

interface mkds_scan_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] active_flags;
    logic [7:0] held_flags;

    modport source (output valid, output active_flags, output held_flags, input ready);
    modport sink (input valid, input active_flags, input held_flags, output ready);
endinterface

interface mkds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  reg_index;
    logic [63:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/multi_key_debounce_scanner.sv
// Latency: a scan transfer shows its result on the output channel in the next cycle.
// Throughput: one scan per cycle; every key lane updates in the same cycle, and the
// single result register accepts a new scan whenever it is empty or being drained.
// Reset (rst_n, asynchronous, active low): all keys idle with zero counts and flags,
// all slots present, active level low, no repeat, press trigger, zero timeouts.
module multi_key_debounce_scanner
    import mkds_pkg::*;
#(
    parameter int NUM_KEYS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    mkds_scan_in_if.sink    scan_in,
    mkds_scan_out_if.source scan_out,
    mkds_cfg_if.sink        cfg
);

    logic [7:0]         present_reg;
    logic [7:0]         active_level_reg;
    logic [7:0]         repeat_reg;
    logic [7:0]         release_trig_reg;
    logic [WDATA_W-1:0] timeout_reg;

    logic                        fire;
    logic                        in_ready;
    key_status_t [KEY_SLOTS-1:0] lane_status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg      <= 8'hFF;
            active_level_reg <= 8'h00;
            repeat_reg       <= 8'h00;
            release_trig_reg <= 8'h00;
            timeout_reg      <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_KEY_PRESENT:     present_reg      <= cfg.wdata[7:0];
                REG_ACTIVE_LEVEL:    active_level_reg <= cfg.wdata[7:0];
                REG_REPEAT:          repeat_reg       <= cfg.wdata[7:0];
                REG_RELEASE_TRIGGER: release_trig_reg <= cfg.wdata[7:0];
                REG_TIMEOUT_TICKS:   timeout_reg      <= cfg.wdata;
                default:
                begin
                    timeout_reg <= timeout_reg;
                end
            endcase
        end
    end

    assign scan_in.ready = in_ready;
    assign fire          = scan_in.valid && in_ready;

    for (genvar k = 0; k < KEY_SLOTS; k++)
    begin : g_lane
        if (k < NUM_KEYS)
        begin : g_used
            key_cfg_t key_cfg;

            assign key_cfg.present      = present_reg[k];
            assign key_cfg.active_level = active_level_reg[k];
            assign key_cfg.repeat_en    = repeat_reg[k];
            assign key_cfg.release_trig = release_trig_reg[k];
            assign key_cfg.timeout      = timeout_reg[CNT_W*k +: CNT_W];

            mkds_lane u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .fire        (fire),
                .raw_bit     (scan_in.raw_levels[k]),
                .ack_bit     (scan_in.ack_mask[k]),
                .key_cfg     (key_cfg),
                .status_next (lane_status[k])
            );
        end
        else
        begin : g_unused
            // Slots beyond the configured key count always report zero.
            assign lane_status[k] = '0;
        end
    end

    mkds_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (scan_in.valid),
        .in_ready     (in_ready),
        .lane_status  (lane_status),
        .out_valid    (scan_out.valid),
        .out_ready    (scan_out.ready),
        .active_flags (scan_out.active_flags),
        .held_flags   (scan_out.held_flags)
    );

endmodule

>>> rtl/mkds_lane.sv
module mkds_lane
    import mkds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        raw_bit,
    input  logic        ack_bit,
    input  key_cfg_t    key_cfg,
    output key_status_t status_next
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BOUNCE  = 2'd1,
        PH_PRESSED = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flag_reg, flag_next;
    logic             pressed;

    assign pressed = (raw_bit == key_cfg.active_level);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (ack_bit)
        begin
            phase_next = PH_IDLE;
            count_next = '0;
            flag_next  = 1'b0;
        end
        if (key_cfg.present)
        begin
            if (pressed)
            begin
                unique case (phase_next)
                    PH_IDLE:
                    begin
                        phase_next = PH_BOUNCE;
                    end
                    PH_BOUNCE:
                    begin
                        if (count_next >= key_cfg.timeout)
                        begin
                            phase_next = PH_PRESSED;
                            if (!key_cfg.release_trig)
                            begin
                                flag_next  = 1'b1;
                                count_next = '0;
                            end
                        end
                    end
                    PH_PRESSED:
                    begin
                        if (key_cfg.repeat_en && (count_next >= key_cfg.timeout))
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_next;
                    end
                endcase
                if (count_next != CNT_MAX)
                begin
                    count_next = count_next + 1'b1;
                end
            end
            else if (key_cfg.release_trig && (count_next >= key_cfg.timeout))
            begin
                // A long enough hold fires on release and keeps its state.
                flag_next = 1'b1;
            end
            else
            begin
                phase_next = PH_IDLE;
                count_next = '0;
                flag_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign status_next.active = flag_next;
    assign status_next.held   = (phase_next == PH_PRESSED);

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (count_reg == '0))
        else $error("idle key holds a nonzero count");

    a_hold_without_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(phase_reg) && $stable(count_reg) && $stable(flag_reg)))
        else $error("key state changed without a scan transfer");

    a_ack_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ack_bit && !key_cfg.present) |=>
            (!flag_reg && (phase_reg == PH_IDLE) && (count_reg == '0)))
        else $error("acknowledged empty slot was not cleared");

endmodule

>>> rtl/mkds_merge.sv
module mkds_merge
    import mkds_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  key_status_t [KEY_SLOTS-1:0] lane_status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [KEY_SLOTS-1:0]       active_flags,
    output logic [KEY_SLOTS-1:0]       held_flags
);

    logic                 valid_reg;
    logic [KEY_SLOTS-1:0] active_reg, active_next;
    logic [KEY_SLOTS-1:0] held_reg, held_next;
    logic                 fire;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            active_next[k] = lane_status[k].active;
            held_next[k]   = lane_status[k].held;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            active_reg <= active_next;
            held_reg   <= held_next;
        end
    end

    assign out_valid    = valid_reg;
    assign active_flags = active_reg;
    assign held_flags   = held_reg;

    a_result_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> valid_reg)
        else $error("accepted scan left no result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg && !out_ready))
        else $error("input stalled while the result register could move");

    a_no_result_without_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(fire) && !$past(valid_reg)) |-> !valid_reg)
        else $error("result appeared without a scan transfer");

endmodule
